// ===== rtl/core/hamming_secded_16_11_stream_encoder_macros.svh =====
`ifndef HAMMING_SECDED_16_11_STREAM_ENCODER_MACROS_SVH
`define HAMMING_SECDED_16_11_STREAM_ENCODER_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low
`define HS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen
`define HS_ASSERT_NEVER(lbl, cond, msg) \
  `HS_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/hsecded_pkg.sv =====
`timescale 1ns / 1ps

package hsecded_pkg;

  localparam int unsigned BlockBits  = 11;
  localparam int unsigned WordBits   = 16;
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned PendBits   = 10;
  localparam int unsigned CountBits  = 4;

  typedef logic [BlockBits-1:0] block_t;
  typedef logic [WordBits-1:0]  word_t;
  typedef logic [PendBits-1:0]  pend_t;
  typedef logic [CountBits-1:0] count_t;

  // Position i (1..16) lands on word bit 16-i; data fills non-power-of-two
  // positions, first data bit (block[10]) at position 3.
  function automatic word_t encode_block(block_t blk);
    logic [16:0] pos;
    logic        tot;
    int          k;
    word_t       w;
    pos = '0;
    k   = BlockBits - 1;
    for (int i = 1; i <= 15; i++) begin
      if ((i & (i - 1)) != 0) begin
        pos[i] = blk[k];
        k--;
      end
    end
    for (int p = 1; p <= 8; p = p * 2) begin
      for (int i = 1; i <= 15; i++) begin
        if (((i & p) != 0) && (i != p)) begin
          pos[p] = pos[p] ^ pos[i];
        end
      end
    end
    tot = 1'b0;
    for (int i = 1; i <= 15; i++) begin
      tot = tot ^ pos[i];
    end
    pos[16] = tot;
    for (int i = 1; i <= 16; i++) begin
      w[16-i] = pos[i];
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/hamming_secded_16_11_stream_encoder.sv =====
`timescale 1ns / 1ps
// Extended Hamming (16,11) SECDED encoder on a byte stream. Bytes enter MSB
// first and are packed into 11-bit blocks; each full block leaves as one
// 16-bit codeword (bit 15 = position 1, bit 0 = overall parity). A byte with
// tlast flushes the remaining bits zero-padded and marks the final codeword
// with tlast. One byte is taken per cycle while the output can accept; a final
// byte that yields two codewords holds the input while the second codeword
// moves from the spare slot into the output register. Output valid and data
// are registered; input ready follows output ready combinationally.

`include "hamming_secded_16_11_stream_encoder_macros.svh"

module hamming_secded_16_11_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // is_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] codeword
  output logic        m_axis_tlast_o    // last_word
);

  hsecded_pkg::pend_t  pend_q, pend_d;
  hsecded_pkg::count_t cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_last_q, out_last_d;
  hsecded_pkg::word_t  out_data_q, out_data_d;
  logic                extra_valid_q, extra_valid_d;
  hsecded_pkg::word_t  extra_data_q, extra_data_d;

  logic                out_free;
  logic                in_xfer;
  logic [17:0]         acc;
  logic                full;
  logic [2:0]          rem;
  hsecded_pkg::block_t block0;
  hsecded_pkg::pend_t  left;
  hsecded_pkg::count_t lo;
  hsecded_pkg::count_t sh;
  hsecded_pkg::block_t pad;
  hsecded_pkg::word_t  cw_full, cw_pad;
  logic                has_first, has_second, last0;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !extra_valid_q && out_free;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Block split and flush padding
  always_comb begin
    acc    = {pend_q, s_axis_tdata_i};
    full   = (cnt_q >= 4'd3);
    rem    = 3'(cnt_q - 4'd3);
    block0 = hsecded_pkg::block_t'(acc >> rem);
    left   = full ? (acc[9:0] & ((10'd1 << rem) - 10'd1)) : acc[9:0];
    lo     = full ? {1'b0, rem} : (cnt_q + 4'd8);
    sh     = 4'd11 - lo;
    pad    = hsecded_pkg::block_t'({1'b0, left} << sh);
  end

  assign cw_full    = hsecded_pkg::encode_block(block0);
  assign cw_pad     = hsecded_pkg::encode_block(pad);
  assign has_first  = full || s_axis_tlast_i;
  assign has_second = full && s_axis_tlast_i && (rem != 3'd0);
  assign last0      = full ? (s_axis_tlast_i && (rem == 3'd0)) : 1'b1;

  always_comb begin
    pend_d        = pend_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q;
    out_last_d    = out_last_q;
    out_data_d    = out_data_q;
    extra_valid_d = extra_valid_q;
    extra_data_d  = extra_data_q;
    if (in_xfer) begin
      pend_d = s_axis_tlast_i ? '0 : left;
      cnt_d  = s_axis_tlast_i ? '0 : lo;
    end
    if (out_free) begin
      if (extra_valid_q) begin
        out_valid_d   = 1'b1;
        out_data_d    = extra_data_q;
        out_last_d    = 1'b1;
        extra_valid_d = 1'b0;
      end else if (in_xfer) begin
        out_valid_d   = has_first;
        out_data_d    = full ? cw_full : cw_pad;
        out_last_d    = last0;
        extra_valid_d = has_second;
        extra_data_d  = cw_pad;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q        <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
      out_last_q    <= 1'b0;
      extra_valid_q <= 1'b0;
    end else begin
      pend_q        <= pend_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
      out_last_q    <= out_last_d;
      extra_valid_q <= extra_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    extra_data_q <= extra_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  `HS_ASSERT(a_extra_behind_out, extra_valid_q |-> out_valid_q, "spare word without output word")
  `HS_ASSERT(a_extra_not_last, extra_valid_q |-> !out_last_q, "final word ahead of spare word")
  `HS_ASSERT_NEVER(a_cnt_range, cnt_q > 4'd10, "pending count above ten")
  `HS_ASSERT(a_flush_clears, (in_xfer && s_axis_tlast_i) |=> (cnt_q == 4'd0), "flush left bits")

endmodule
